// ----- rtl/core/fwv_pkg.sv -----
// fwv_pkg: shared types, codes and constants of the firmware image validator.
// No dependencies.
`default_nettype none
package fwv_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int SIZE_BITS_DEF    = 24;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int BLK_AW     = 4;
  localparam int BLK_WORDS  = 16;

  localparam logic [7:0]  IMG_MAGIC  = 8'hE9;
  localparam logic [7:0]  XOR_SEED   = 8'hEF;
  localparam logic [15:0] CHIP_ANY   = 16'hFFFF;
  localparam int          HDR_LEN    = 24;
  localparam int          SIZE_LIMIT_RST = 32'h0064_0000;
  localparam int          MIN_SIZE_RST   = 64 * 1024;

  typedef enum logic [1:0] {
    REG_IMAGE_SIZE  = 2'd0,
    REG_SIZE_LIMIT  = 2'd1,
    REG_MIN_SIZE    = 2'd2,
    REG_DEVICE_CHIP = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    VD_OK        = 3'd0,
    VD_TOO_SMALL = 3'd1,
    VD_TOO_LARGE = 3'd2,
    VD_BAD_MAGIC = 3'd3,
    VD_WRONG_CHIP= 3'd4,
    VD_INVALID   = 3'd5,
    VD_SHORT     = 3'd6
  } verdict_t;

  typedef enum logic [2:0] {
    PH_HDR, PH_SEGHDR, PH_DATA, PH_PAD, PH_TRAIL, PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {
    C_RUN, C_HASH, C_FIN
  } ctl_t;

  typedef enum logic [1:0] {
    SH_IDLE, SH_LOAD, SH_ROUND, SH_ADD
  } sha_state_t;

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fwv_if.sv -----
// fwv_if: handshake channels of the validator (image bytes, verdicts, config).
// Depends on fwv_pkg.
`default_nettype none
interface fwv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface fwv_verdict_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;
  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

interface fwv_cfg_if import fwv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/fwv_ram.sv -----
// fwv_ram: generic simple dual-port RAM, one write port, registered read.
// No dependencies.
`default_nettype none
module fwv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/fwv_sha.sv -----
// fwv_sha: SHA-256 block engine, one round per cycle, reads the block from RAM.
// Depends on fwv_pkg.
`default_nettype none
module fwv_sha import fwv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              init,
  input  logic              start,
  output logic [BLK_AW-1:0] rd_addr,
  input  logic [31:0]       rd_data,
  output logic              busy,
  input  logic [4:0]        dsel,
  output logic [7:0]        dbyte
);
  sha_state_t  st;
  logic [5:0]  cnt;
  logic        rd_pend;
  logic [31:0] win [16];
  logic [31:0] v [8];
  logic [31:0] hw [8];
  logic [31:0] t1, t2, w_new, s0, s1, e1, a0, ch, mj;

  assign busy    = (st != SH_IDLE);
  assign rd_addr = cnt[BLK_AW-1:0];
  assign dbyte   = hw[dsel[4:2]][{~dsel[1:0], 3'b000} +: 8];

  always_comb begin
    s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    w_new = win[0] + s0 + win[9] + s1;
    e1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + e1 + ch + SHA_K[cnt] + win[0];
    a0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = a0 + mj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= SH_IDLE;
      cnt     <= '0;
      rd_pend <= 1'b0;
      for (int i = 0; i < 8; i++) hw[i] <= SHA_H0[i];
    end else begin
      case (st)
        SH_IDLE: begin
          if (init) begin
            for (int i = 0; i < 8; i++) hw[i] <= SHA_H0[i];
          end
          if (start) begin
            st      <= SH_LOAD;
            cnt     <= '0;
            rd_pend <= 1'b0;
          end
        end
        SH_LOAD: begin
          rd_pend <= !cnt[4];
          if (!cnt[4]) cnt <= cnt + 6'd1;
          if (rd_pend) begin
            for (int i = 0; i < 15; i++) win[i] <= win[i+1];
            win[15] <= rd_data;
          end
          if (cnt[4] && rd_pend) begin
            st  <= SH_ROUND;
            cnt <= '0;
            for (int i = 0; i < 8; i++) v[i] <= hw[i];
          end
        end
        SH_ROUND: begin
          for (int i = 0; i < 15; i++) win[i] <= win[i+1];
          win[15] <= w_new;
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd63) st <= SH_ADD;
        end
        SH_ADD: begin
          for (int i = 0; i < 8; i++) hw[i] <= hw[i] + v[i];
          st <= SH_IDLE;
        end
        default: st <= SH_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/firmware_image_validator_unit.sv -----
// Firmware image validator: one byte per cycle outside hash work, while the
// spare verdict slot is empty. Each 64-byte block stalls input while the block
// words load, the rounds run, the final add is done and control hands back.
// Digest padding adds pad bytes, maybe one more block. A verdict is registered
// in the output slot, or the spare slot while that waits; two verdicts can wait
// before input stalls. Synchronous reset restores registers and rearms.
`default_nettype none
module firmware_image_validator_unit import fwv_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int SIZE_BITS    = SIZE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  fwv_byte_if.sink      image,
  fwv_verdict_if.source result,
  fwv_cfg_if.sink       cfg
);
  localparam int SW = SIZE_BITS;

  logic [SW-1:0] size_img, size_lim, size_min;
  logic [15:0]   dev_chip;

  phase_t        phase, phase_next;
  ctl_t          ctl, ctl_next;
  logic [SW-1:0] pos, pos_next, pos_n;
  logic [7:0]    seg_left, seg_left_next, seg_left_dec;
  logic [31:0]   seg_rem, seg_rem_next, seg_rem_upd;
  logic [5:0]    lshift, lshift_next;
  logic [15:0]   chip, chip_next, chip_full;
  logic          hash_flag, hash_flag_next;
  logic [7:0]    xsum, xsum_next;
  logic [4:0]    pad_rem, pad_rem_next, pad_dec;
  logic [23:0]   wbuf, wbuf_next;
  logic [5:0]    fin_idx, fin_idx_next;
  logic          fin_first, fin_first_next, fin_two, fin_two_next, two_now;
  logic          fin_more, fin_more_next;
  logic          res_valid, res_valid_next;
  verdict_t      res_verdict, res_verdict_next;
  logic          spare_valid, spare_valid_next;
  verdict_t      spare_verdict, spare_verdict_next;

  logic          in_acc, b_last, v_set, absorb, seg_done, rearm, emit;
  verdict_t      v_code;
  logic [7:0]    b, fb;
  logic [5:0]    idx;
  logic [63:0]   len_bits;
  logic [SW:0]   pad_end;
  logic [SW+1:0] expected;
  logic          seghdr_ovf, total_bad, data_ovf;

  logic              ram_we;
  logic [BLK_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;
  logic              sha_start, sha_init, sha_busy;
  logic [7:0]        dig_byte;

  fwv_ram #(.WIDTH(32), .DEPTH(BLK_WORDS)) u_blk (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  fwv_sha u_sha (
    .clk(clk), .rst(rst), .init(sha_init), .start(sha_start),
    .rd_addr(ram_raddr), .rd_data(ram_rdata), .busy(sha_busy),
    .dsel(lshift[4:0]), .dbyte(dig_byte)
  );

  assign cfg.ready     = 1'b1;
  assign image.ready   = (ctl == C_RUN) && !spare_valid;
  assign result.valid  = res_valid;
  assign result.verdict = res_verdict;
  assign in_acc        = image.valid && image.ready;
  assign b             = image.data_byte;
  assign b_last        = image.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_img <= '0;
      size_lim <= SW'(SIZE_LIMIT_RST);
      size_min <= SW'(MIN_SIZE_RST);
      dev_chip <= CHIP_ANY;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_IDX_W'(REG_IMAGE_SIZE):  size_img <= cfg.data[SW-1:0];
        CFG_IDX_W'(REG_SIZE_LIMIT):  size_lim <= cfg.data[SW-1:0];
        CFG_IDX_W'(REG_MIN_SIZE):    size_min <= cfg.data[SW-1:0];
        CFG_IDX_W'(REG_DEVICE_CHIP): dev_chip <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // length checks, all on the position after the current byte
  always_comb begin
    pos_n        = pos + SW'(1);
    idx          = pos[5:0];
    seghdr_ovf   = ({1'b0, pos_n} + (SW+1)'(8)) > {1'b0, size_img};
    seg_left_dec = seg_left - 8'(seg_left != 8'd0);
    pad_end      = ({1'b0, pos_n} + (SW+1)'(16)) & ~(SW+1)'(15);
    expected     = {1'b0, pad_end} + (hash_flag ? (SW+2)'(32) : (SW+2)'(0));
    total_bad    = expected != {2'b00, size_img};
    seg_rem_upd  = seg_rem | (32'(b) << {lshift[1:0], 3'b000});
    data_ovf     = ({1'b0, 32'(pos_n)} + {1'b0, seg_rem_upd}) > {1'b0, 32'(size_img)};
    pad_dec      = pad_rem - 5'(pad_rem != 5'd0);
    chip_full    = {b, chip[7:0]};
    len_bits     = 64'(pos) << 3;
    two_now      = fin_first ? (fin_idx[5:3] == 3'b111) : fin_two;
    fb           = fin_first ? 8'h80 :
                   ((fin_idx[5:3] == 3'b111) && !fin_two) ?
                   len_bits[{~fin_idx[2:0], 3'b000} +: 8] : 8'h00;
  end

  always_comb begin
    phase_next = phase;       ctl_next = ctl;
    pos_next = pos;           seg_left_next = seg_left;
    seg_rem_next = seg_rem;   lshift_next = lshift;
    chip_next = chip;         hash_flag_next = hash_flag;
    xsum_next = xsum;         pad_rem_next = pad_rem;
    wbuf_next = wbuf;         fin_idx_next = fin_idx;
    fin_first_next = fin_first; fin_two_next = fin_two;
    fin_more_next = fin_more;
    res_valid_next = res_valid && !result.ready;
    res_verdict_next = res_verdict;
    spare_valid_next = spare_valid;
    spare_verdict_next = spare_verdict;
    if (spare_valid && res_valid && result.ready) begin
      res_valid_next = 1'b1;
      res_verdict_next = spare_verdict;
      spare_valid_next = 1'b0;
    end
    ram_we = 1'b0; ram_waddr = idx[5:2]; ram_wdata = {wbuf, b};
    sha_start = 1'b0; sha_init = 1'b0;
    v_set = 1'b0; v_code = VD_OK; absorb = 1'b0; seg_done = 1'b0;
    rearm = 1'b0; emit = 1'b0;

    case (ctl)
      C_RUN: begin
        if (in_acc) begin
          if (phase == PH_DRAIN) begin
            rearm = b_last;
          end else begin
            case (phase)
              PH_HDR: begin
                if (pos == '0 && size_img < size_min) begin
                  v_set = 1'b1; v_code = VD_TOO_SMALL;
                end else if (pos == '0 && size_img > size_lim) begin
                  v_set = 1'b1; v_code = VD_TOO_LARGE;
                end else if (pos == '0 && size_img < SW'(HDR_LEN)) begin
                  v_set = 1'b1; v_code = VD_SHORT;
                end else begin
                  absorb = 1'b1;
                  if (pos == SW'(0)) begin
                    if (b != IMG_MAGIC) begin
                      v_set = 1'b1; v_code = VD_BAD_MAGIC;
                    end
                  end else if (pos == SW'(1)) begin
                    seg_left_next = b;
                  end else if (pos == SW'(12)) begin
                    chip_next = {8'h00, b};
                  end else if (pos == SW'(13)) begin
                    chip_next = chip_full;
                    if (dev_chip != CHIP_ANY && chip_full != dev_chip) begin
                      v_set = 1'b1; v_code = VD_WRONG_CHIP;
                    end else if (seg_left == 8'd0 || seg_left > 8'(MAX_SEGMENTS)) begin
                      v_set = 1'b1; v_code = VD_INVALID;
                    end
                  end else if (pos == SW'(HDR_LEN - 1)) begin
                    hash_flag_next = (b != 8'd0);
                    if (seghdr_ovf) begin
                      v_set = 1'b1; v_code = VD_INVALID;
                    end else begin
                      phase_next = PH_SEGHDR; lshift_next = '0; seg_rem_next = '0;
                    end
                  end
                end
              end
              PH_SEGHDR: begin
                absorb = 1'b1;
                if (lshift[2]) seg_rem_next = seg_rem_upd;
                lshift_next = lshift + 6'd1;
                if (lshift == 6'd7) begin
                  if (data_ovf) begin
                    v_set = 1'b1; v_code = VD_INVALID;
                  end else if (seg_rem_upd == '0) begin
                    seg_done = 1'b1;
                  end else begin
                    phase_next = PH_DATA;
                  end
                end
              end
              PH_DATA: begin
                absorb = 1'b1;
                xsum_next = xsum ^ b;
                seg_rem_next = seg_rem - 32'd1;
                if (seg_rem == 32'd1) seg_done = 1'b1;
              end
              PH_PAD: begin
                absorb = 1'b1;
                pad_rem_next = pad_dec;
                if (pad_dec == 5'd0) begin
                  if (b != xsum) begin
                    v_set = 1'b1; v_code = VD_INVALID;
                  end else if (hash_flag) begin
                    phase_next = PH_TRAIL; lshift_next = '0;
                    fin_first_next = 1'b1; fin_two_next = 1'b0;
                    fin_idx_next = pos_n[5:0];
                    fin_more_next = 1'b1;
                    ctl_next = C_FIN;
                  end else begin
                    v_set = 1'b1; v_code = VD_OK;
                  end
                end
              end
              default: begin
                if (b != dig_byte) begin
                  v_set = 1'b1; v_code = VD_INVALID;
                end else begin
                  lshift_next = lshift + 6'd1;
                  if (lshift == 6'd31) begin
                    v_set = 1'b1; v_code = VD_OK;
                  end
                end
              end
            endcase

            if (seg_done) begin
              seg_left_next = seg_left_dec;
              if (seg_left_dec != 8'd0) begin
                if (seghdr_ovf) begin
                  v_set = 1'b1; v_code = VD_INVALID;
                end else begin
                  phase_next = PH_SEGHDR; lshift_next = '0; seg_rem_next = '0;
                end
              end else if (total_bad) begin
                v_set = 1'b1; v_code = VD_INVALID;
              end else begin
                pad_rem_next = 5'(pad_end - {1'b0, pos_n});
                phase_next = PH_PAD;
              end
            end

            if (absorb) begin
              ram_we = (idx[1:0] == 2'b11);
              wbuf_next = {wbuf[15:0], b};
              pos_next = pos_n;
            end

            if (v_set || b_last) begin
              emit = 1'b1;
              if (!v_set) v_code = VD_SHORT;
              if (b_last) rearm = 1'b1;
              else begin
                phase_next = PH_DRAIN;
                ctl_next = C_RUN;
              end
            end else if (absorb && idx == 6'd63) begin
              sha_start = 1'b1;
              ctl_next = C_HASH;
            end else begin
              fin_more_next = 1'b0;
            end
          end
        end
      end
      C_HASH: begin
        if (!sha_busy) begin
          if (fin_more) begin
            fin_more_next = 1'b0;
            ctl_next = C_FIN;
          end else begin
            ctl_next = C_RUN;
          end
        end
      end
      C_FIN: begin
        ram_waddr = fin_idx[5:2];
        ram_wdata = {wbuf, fb};
        ram_we = (fin_idx[1:0] == 2'b11);
        wbuf_next = {wbuf[15:0], fb};
        fin_first_next = 1'b0;
        fin_idx_next = fin_idx + 6'd1;
        if (fin_idx == 6'd63) begin
          sha_start = 1'b1;
          fin_more_next = two_now;
          fin_two_next = 1'b0;
          ctl_next = C_HASH;
        end else begin
          fin_two_next = two_now;
        end
      end
      default: ctl_next = C_RUN;
    endcase

    // a verdict goes to the spare slot while the output slot still waits
    if (emit) begin
      if (res_valid_next) begin
        spare_valid_next = 1'b1;
        spare_verdict_next = v_code;
      end else begin
        res_valid_next = 1'b1;
        res_verdict_next = v_code;
      end
    end

    if (rearm) begin
      sha_init = 1'b1;
      sha_start = 1'b0;
      phase_next = PH_HDR;   ctl_next = C_RUN;
      pos_next = '0;         seg_left_next = '0;
      seg_rem_next = '0;     lshift_next = '0;
      chip_next = '0;        hash_flag_next = 1'b0;
      xsum_next = XOR_SEED;  pad_rem_next = '0;
      fin_first_next = 1'b0; fin_two_next = 1'b0; fin_more_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR;
      ctl       <= C_RUN;
      pos       <= '0;
      seg_left  <= '0;
      seg_rem   <= '0;
      lshift    <= '0;
      chip      <= '0;
      hash_flag <= 1'b0;
      xsum      <= XOR_SEED;
      pad_rem   <= '0;
      fin_idx   <= '0;
      fin_first <= 1'b0;
      fin_two   <= 1'b0;
      fin_more  <= 1'b0;
      res_valid <= 1'b0;
      spare_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      ctl       <= ctl_next;
      pos       <= pos_next;
      seg_left  <= seg_left_next;
      seg_rem   <= seg_rem_next;
      lshift    <= lshift_next;
      chip      <= chip_next;
      hash_flag <= hash_flag_next;
      xsum      <= xsum_next;
      pad_rem   <= pad_rem_next;
      fin_idx   <= fin_idx_next;
      fin_first <= fin_first_next;
      fin_two   <= fin_two_next;
      fin_more  <= fin_more_next;
      res_valid <= res_valid_next;
      spare_valid <= spare_valid_next;
    end
    wbuf        <= wbuf_next;
    res_verdict <= res_verdict_next;
    spare_verdict <= spare_verdict_next;
  end

`ifndef SYNTHESIS
  a_no_word_while_hashing: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> !sha_busy)
    else $error("image word accepted while hash engine busy");

  a_verdict_from_word: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(in_acc))
    else $error("verdict raised without an accepted word");

  a_fin_in_trailer: assert property (@(posedge clk) disable iff (rst)
    (ctl == C_FIN) |-> (phase == PH_TRAIL))
    else $error("digest padding outside trailer phase");

  a_spare_behind_head: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> res_valid)
    else $error("spare verdict held with empty output slot");
`endif
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench of firmware_image_validator_unit.
// Streams built and corrupted images, predicts each verdict in SV.
// Depends on fwv_pkg, the fwv interfaces and the validator RTL.
`timescale 1ns / 100ps
module tb_top;
  import fwv_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } image_word_t;

  typedef enum int {
    M_OK, M_FLIP, M_TRUNC, M_SIZE, M_EXTRA, M_TRAIL, M_MAGIC, M_SEGS0, M_SEGS17, M_NOISE
  } img_mode_t;

  logic clk = 1'b0;
  logic rst;

  fwv_byte_if    img_if ();
  fwv_verdict_if res_if ();
  fwv_cfg_if     cfg_if ();

  firmware_image_validator_unit dut (
    .clk    (clk),
    .rst    (rst),
    .image  (img_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  always #5 clk = ~clk;

  image_word_t pend_words[$];
  verdict_t    verdicts_due[$];
  int          errors = 0;
  int          nbytes = 0;
  bit          squeeze_go = 0;

  // mirrored registers
  logic [23:0] r_size, r_limit, r_min;
  logic [15:0] r_chip;

  // predicted validator state
  phase_t          ph;
  logic [7:0]      absorbed[$];
  int              seg_left;
  longint unsigned seg_rem;
  int              len_sh;
  logic [15:0]     img_chip;
  bit              hash_p;
  logic [7:0]      xsum;
  int              pad_rem;
  logic [255:0]    digest;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha256_of(input logic [7:0] msg[$]);
    logic [7:0]      m[$];
    logic [31:0]     h[8];
    logic [31:0]     w[64];
    logic [31:0]     a, bb, c, d, e, f, g, hh, t1, t2, s0, s1;
    longint unsigned nbits;
    int              blk, i;
    m = msg;
    nbits = 64'(msg.size()) * 8;
    m.push_back(8'h80);
    while (m.size() % 64 != 56) m.push_back(8'h00);
    for (i = 7; i >= 0; i--) m.push_back(nbits[8*i +: 8]);
    for (i = 0; i < 8; i++) h[i] = SHA_H0[i];
    for (blk = 0; blk < m.size(); blk += 64) begin
      for (i = 0; i < 16; i++)
        w[i] = {m[blk+4*i], m[blk+4*i+1], m[blk+4*i+2], m[blk+4*i+3]};
      for (i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = h[0]; bb = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
      for (i = 0; i < 64; i++) begin
        s1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
        t1 = hh + s1 + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
        s0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
        t2 = s0 + ((a & bb) ^ (a & c) ^ (bb & c));
        hh = g; g = f; f = e; e = d + t1; d = c; c = bb; bb = a; a = t1 + t2;
      end
      h[0] += a; h[1] += bb; h[2] += c; h[3] += d;
      h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
    end
    return {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
  endfunction

  function void rearm();
    ph = PH_HDR;
    absorbed.delete();
    seg_left = 0;
    seg_rem = 0;
    len_sh = 0;
    img_chip = 0;
    hash_p = 0;
    xsum = XOR_SEED;
    pad_rem = 0;
  endfunction

  function int open_seg_header();
    if (absorbed.size() + 8 > r_size) return VD_INVALID;
    ph = PH_SEGHDR;
    len_sh = 0;
    seg_rem = 0;
    return -1;
  endfunction

  function int close_segment();
    longint unsigned pad_end, total;
    if (seg_left > 0) seg_left--;
    if (seg_left > 0) return open_seg_header();
    pad_end = (absorbed.size() + 16) & ~64'd15;
    total = pad_end + (hash_p ? 32 : 0);
    if (total != r_size) return VD_INVALID;
    pad_rem = int'(pad_end) - absorbed.size();
    ph = PH_PAD;
    return -1;
  endfunction

  function void predict_byte(input logic [7:0] b, input bit last);
    int v, i;
    v = -1;
    if (ph == PH_DRAIN) begin
      if (last) rearm();
      return;
    end
    case (ph)
      PH_HDR: begin
        i = absorbed.size();
        if (i == 0) begin
          if (r_size < r_min) v = VD_TOO_SMALL;
          else if (r_size > r_limit) v = VD_TOO_LARGE;
          else if (r_size < HDR_LEN) v = VD_SHORT;
        end
        if (v < 0) begin
          absorbed.push_back(b);
          if (i == 0) begin
            if (b != IMG_MAGIC) v = VD_BAD_MAGIC;
          end else if (i == 1) begin
            seg_left = b;
          end else if (i == 12) begin
            img_chip = {8'h00, b};
          end else if (i == 13) begin
            img_chip[15:8] = b;
            if (r_chip != CHIP_ANY && img_chip != r_chip) v = VD_WRONG_CHIP;
            else if (seg_left == 0 || seg_left > MAX_SEGMENTS_DEF) v = VD_INVALID;
          end else if (i == 23) begin
            hash_p = (b != 0);
            v = open_seg_header();
          end
        end
      end
      PH_SEGHDR: begin
        absorbed.push_back(b);
        if (len_sh >= 4) seg_rem |= longint'(b) << (8 * (len_sh - 4));
        len_sh++;
        if (len_sh == 8) begin
          if (absorbed.size() + seg_rem > r_size) v = VD_INVALID;
          else if (seg_rem == 0) v = close_segment();
          else ph = PH_DATA;
        end
      end
      PH_DATA: begin
        absorbed.push_back(b);
        xsum ^= b;
        seg_rem--;
        if (seg_rem == 0) v = close_segment();
      end
      PH_PAD: begin
        absorbed.push_back(b);
        if (pad_rem > 0) pad_rem--;
        if (pad_rem == 0) begin
          if (b != xsum) v = VD_INVALID;
          else if (hash_p) begin
            digest = sha256_of(absorbed);
            ph = PH_TRAIL;
            len_sh = 0;
          end else v = VD_OK;
        end
      end
      default: begin
        if (b != digest[255 - 8*len_sh -: 8]) v = VD_INVALID;
        else begin
          len_sh++;
          if (len_sh >= 32) v = VD_OK;
        end
      end
    endcase
    if (v < 0 && last) v = VD_SHORT;
    if (v < 0) return;
    verdicts_due.push_back(verdict_t'(v));
    if (last) rearm();
    else ph = PH_DRAIN;
  endfunction

  // sender: bursts and gaps
  image_word_t cur_word;
  int burst = 1, gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      img_if.valid <= 1'b0;
    end else if (!img_if.valid || img_if.ready) begin
      if (gap > 0) begin
        gap <= gap - 1;
        img_if.valid <= 1'b0;
      end else if (pend_words.size() > 0) begin
        cur_word = pend_words.pop_front();
        img_if.valid     <= 1'b1;
        img_if.data_byte <= cur_word.b;
        img_if.last_byte <= cur_word.last;
        if (burst <= 1) begin
          burst <= $urandom_range(1, 64);
          gap   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else burst <= burst - 1;
      end else begin
        img_if.valid <= 1'b0;
      end
    end
  end

  // receiver: stall modes plus one long hold-off
  int  hold = 0, rmode = 0, rmode_left = 0;
  bit  squeeze_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold > 0) begin
      hold <= hold - 1;
      res_if.ready <= 1'b0;
    end else if (squeeze_go && !squeeze_done) begin
      hold <= 3000;
      squeeze_done <= 1'b1;
      res_if.ready <= 1'b0;
    end else begin
      if (rmode_left == 0) begin
        rmode <= $urandom_range(0, 2);
        rmode_left <= $urandom_range(20, 300);
      end else rmode_left <= rmode_left - 1;
      case (rmode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= $urandom_range(0, 1);
        default: res_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor, predictor hookup and watchdog
  verdict_t want;
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, actual %0d", $time, res_if.verdict);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (res_if.verdict !== want) begin
            $display("%0t: verdict mismatch, expected %0d, actual %0d",
                     $time, want, res_if.verdict);
            errors++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_IMAGE_SIZE:  r_size  <= cfg_if.data[23:0];
          REG_SIZE_LIMIT:  r_limit <= cfg_if.data[23:0];
          REG_MIN_SIZE:    r_min   <= cfg_if.data[23:0];
          REG_DEVICE_CHIP: r_chip  <= cfg_if.data[15:0];
          default: ;
        endcase
      end
      if (img_if.valid && img_if.ready) predict_byte(img_if.data_byte, img_if.last_byte);
      if ((res_if.valid && res_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (img_if.valid && img_if.ready)) idle_cycles <= 0;
      else if (idle_cycles >= 20000) begin
        $display("%0t: watchdog expired", $time);
        $display("** firmware_image_validator_unit: FAILED **");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [7:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_regs(input int sz, input int lim, input int mn, input int chip);
    cfg_write(8'(REG_IMAGE_SIZE), sz);
    cfg_write(8'(REG_SIZE_LIMIT), lim);
    cfg_write(8'(REG_MIN_SIZE), mn);
    cfg_write(8'(REG_DEVICE_CHIP), chip);
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pend_words.size() != 0 || img_if.valid || verdicts_due.size() != 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input bit last);
    pend_words.push_back('{b: b, last: last});
    nbytes++;
  endtask

  task automatic make_image(input int nseg, input bit hsh, input img_mode_t md,
                            input int dev_md, input int maxlen);
    logic [7:0]   img[$];
    logic [7:0]   xs;
    logic [15:0]  chip;
    logic [255:0] dg;
    int           len, pe, sz, i, s, lim, mn, dev;
    chip = 16'($urandom);
    if (dev_md == 2 && chip == 0) chip = 16'h0001;
    for (i = 0; i < 24; i++) img.push_back(8'($urandom));
    img[0]  = IMG_MAGIC;
    img[1]  = 8'(nseg);
    img[12] = chip[7:0];
    img[13] = chip[15:8];
    img[23] = hsh ? 8'($urandom_range(1, 255)) : 8'h00;
    xs = XOR_SEED;
    for (s = 0; s < nseg; s++) begin
      len = $urandom_range(0, maxlen);
      for (i = 0; i < 4; i++) img.push_back(8'($urandom));
      for (i = 0; i < 4; i++) img.push_back(8'(len >> (8 * i)));
      for (i = 0; i < len; i++) begin
        img.push_back(8'($urandom));
        xs ^= img[img.size()-1];
      end
    end
    pe = (img.size() + 16) & ~15;
    while (img.size() < pe - 1) img.push_back(8'($urandom));
    img.push_back(xs);
    if (hsh) begin
      dg = sha256_of(img);
      for (i = 0; i < 32; i++) img.push_back(dg[255 - 8*i -: 8]);
    end
    sz = img.size();
    case (md)
      M_FLIP:   begin i = $urandom_range(0, sz - 1); img[i] ^= 8'(1 << $urandom_range(0, 7)); end
      M_TRUNC:  img = img[0 : $urandom_range(0, sz - 2)];
      M_SIZE:   sz = $urandom_range(0, 1) ? sz + 16 : sz - 16;
      M_EXTRA:  repeat ($urandom_range(1, 5)) img.push_back(8'($urandom));
      M_TRAIL:  begin i = sz - 1 - $urandom_range(0, 31); img[i] ^= 8'(1 << $urandom_range(0, 7)); end
      M_MAGIC:  img[0] = IMG_MAGIC ^ 8'($urandom_range(1, 255));
      M_SEGS0:  img[1] = 8'h00;
      M_SEGS17: img[1] = 8'(MAX_SEGMENTS_DEF + 1);
      M_NOISE: begin
        img.delete();
        repeat ($urandom_range(1, 40)) img.push_back(8'($urandom));
        if ($urandom_range(0, 1)) img[0] = IMG_MAGIC;
        sz = $urandom_range(24, 200);
      end
      default: ;
    endcase
    lim = $urandom_range(0, 1) ? 24'hFFFFFF : $urandom_range(sz, 24'hFFFFFF);
    mn  = $urandom_range(0, 1) ? 0 : $urandom_range(0, sz);
    if (dev_md == 0) dev = CHIP_ANY;
    else if (dev_md == 1) dev = chip;
    else dev = $urandom_range(0, 1) ? 0 : (chip ^ 16'h0100);
    set_regs(sz, lim, mn, dev);
    for (i = 0; i < img.size(); i++) push_byte(img[i], i == img.size() - 1);
    settle();
  endtask

  img_mode_t rmd;
  int        pick, nsg;
  bit        hs;
  initial begin
    rst = 1'b1;
    img_if.valid = 1'b0; img_if.data_byte = 8'h00; img_if.last_byte = 1'b0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    r_size = 0; r_limit = SIZE_LIMIT_RST; r_min = MIN_SIZE_RST; r_chip = CHIP_ANY;
    rearm();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset defaults: size 0 is below the minimum
    push_byte(IMG_MAGIC, 1'b1);
    settle();
    // unused indexes change nothing
    cfg_write(8'd4, $urandom);
    cfg_write(8'hFF, $urandom);
    push_byte(IMG_MAGIC, 1'b1);
    settle();
    set_regs(24'hFFFFFF, SIZE_LIMIT_RST, 0, CHIP_ANY);
    push_byte(IMG_MAGIC, 1'b1);
    settle();
    set_regs(10, 24'hFFFFFF, 0, CHIP_ANY);
    push_byte(IMG_MAGIC, 1'b1);
    settle();
    set_regs(100, 24'hFFFFFF, 24'hFFFFFF, 0);
    push_byte(8'h00, 1'b1);
    settle();
    set_regs(0, 0, 0, CHIP_ANY);
    push_byte(8'hFF, 1'b1);
    settle();

    make_image(1, 0, M_OK, 0, 8);
    make_image(2, 1, M_OK, 1, 16);
    make_image(1, 0, M_MAGIC, 0, 8);
    make_image(1, 0, M_OK, 2, 8);
    make_image(2, 0, M_SEGS0, 0, 8);
    make_image(2, 0, M_SEGS17, 0, 8);
    make_image(MAX_SEGMENTS_DEF, 0, M_OK, 0, 2);
    make_image(1, 1, M_TRAIL, 0, 8);
    make_image(2, 0, M_TRUNC, 0, 16);
    make_image(1, 1, M_EXTRA, 1, 8);
    make_image(1, 0, M_SIZE, 0, 8);

    // long receiver hold-off while back-to-back rejected images back up the input
    squeeze_go = 1'b1;
    set_regs(64, 24'hFFFFFF, 0, CHIP_ANY);
    repeat (6) begin
      push_byte(8'h00, 1'b0);
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b1);
    end
    settle();

    while (nbytes < 1600) begin
      pick = $urandom_range(0, 99);
      hs   = $urandom_range(0, 1);
      if (pick < 45) rmd = M_OK;
      else if (pick < 55) rmd = M_FLIP;
      else if (pick < 63) rmd = M_TRUNC;
      else if (pick < 70) rmd = M_SIZE;
      else if (pick < 78) rmd = M_EXTRA;
      else if (pick < 83) begin rmd = M_TRAIL; hs = 1; end
      else if (pick < 86) rmd = M_MAGIC;
      else if (pick < 88) rmd = M_SEGS0;
      else if (pick < 90) rmd = M_SEGS17;
      else rmd = M_NOISE;
      nsg = ($urandom_range(0, 19) == 0) ? MAX_SEGMENTS_DEF : $urandom_range(1, 4);
      make_image(nsg, hs, rmd, ($urandom_range(0, 6) == 0) ? 2 : $urandom_range(0, 1),
                 (nsg > 4) ? 4 : 24);
    end

    settle();
    if (errors == 0 && verdicts_due.size() == 0)
      $display("** firmware_image_validator_unit: PASSED **");
    else
      $display("** firmware_image_validator_unit: FAILED **");
    $finish;
  end
endmodule
